/* rtl/core/tiled_texture_span_sampler_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tiled texture span sampler
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef TILED_TEXTURE_SPAN_SAMPLER_ASSERT_SVH
`define TILED_TEXTURE_SPAN_SAMPLER_ASSERT_SVH

// checked only while out of reset
`define TTS_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define TTS_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/core/tts_pkg.sv */
// ----------------------------------------------------------------------------
// tts_pkg
// Types and constants shared by the span sampler modules.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TEX_LOG2    = 8;
    localparam int TEX_XY_W    = 2 * TEX_LOG2;
    localparam int TEX_ADDR_W  = 16;
    localparam int TEX_DEPTH   = 1 << TEX_ADDR_W;
    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = COLOR_W / CHAN_W;
    localparam int FRAC_W      = 16;
    localparam int WEIGHT_W    = FRAC_W + 1;
    localparam int ACC_W       = WEIGHT_W + CHAN_W;
    localparam int COORD_W     = 32;
    localparam int LEVEL_W     = 4;
    localparam int SPAN_W      = 16;
    localparam int NUM_TAPS    = 4;
    localparam int TAP_W       = $clog2(NUM_TAPS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_PRODUCE = 1'b1;

    localparam logic [COORD_W-1:0]  RST_STEP_U      = 32'd65536;
    localparam logic [SPAN_W-1:0]   RST_SPAN_LENGTH = 16'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 17'd65536;

    typedef logic [TEX_LOG2-1:0]   tex_coord_t;
    typedef logic [TEX_ADDR_W-1:0] tex_addr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIP_LEVEL       = 3'd0,
        CFG_START_U         = 3'd1,
        CFG_START_V         = 3'd2,
        CFG_STEP_U          = 3'd3,
        CFG_STEP_V          = 3'd4,
        CFG_FILTER_BILINEAR = 3'd5,
        CFG_SPAN_LENGTH     = 3'd6
    } tts_cfg_idx_t;

    typedef struct packed {
        logic                  cmd;
        logic [TEX_ADDR_W-1:0] texel_addr;
        logic [COLOR_W-1:0]    texel_color;
    } tts_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               span_end;
    } tts_out_t;

    // one queued job: a texel write or a classified pixel fetch
    typedef struct packed {
        logic                               is_write;
        logic [NUM_TAPS-1:0][TEX_ADDR_W-1:0] addr;
        logic [COLOR_W-1:0]                 color;
        logic [FRAC_W-1:0]                  fu;
        logic [FRAC_W-1:0]                  fv;
        logic                               bilinear;
        logic                               last;
    } tts_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_LAST,
        BK_EMIT
    } tts_back_state_t;

endpackage

/* rtl/core/tts_ram.sv */
// ----------------------------------------------------------------------------
// tts_ram
// Generic single write port memory with one registered read port.
// ----------------------------------------------------------------------------
module tts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/tts_front.sv */
// ----------------------------------------------------------------------------
// tts_front
// Configuration registers, span walker and texel address generation.
// ----------------------------------------------------------------------------
module tts_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tts_pkg::tts_in_t                 s_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             push_valid,
    input  logic                             push_ready,
    output tts_pkg::tts_job_t                push_job
);
    import tts_pkg::*;

    localparam tex_coord_t ALL_ONES = '1;

    logic [LEVEL_W-1:0] mip_reg;
    logic [COORD_W-1:0] start_u_reg;
    logic [COORD_W-1:0] start_v_reg;
    logic [COORD_W-1:0] step_u_reg;
    logic [COORD_W-1:0] step_v_reg;
    logic               bilinear_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic [COORD_W-1:0] u_reg, u_next;
    logic [COORD_W-1:0] v_reg, v_next;
    logic [SPAN_W-1:0]  idx_reg, idx_next;

    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] side_log2;
    logic [4:0]         int_shift;
    logic [COORD_W-1:0] u_int, v_int;
    tex_coord_t         mask, x0, y0, x1, y1;
    logic [SPAN_W-1:0]  span_len;
    logic               last;
    logic               take;

    function automatic tex_addr_t tex_addr(tex_coord_t x, tex_coord_t y,
                                           logic [LEVEL_W-1:0] sh);
        logic [TEX_XY_W-1:0] lin;
        lin = TEX_XY_W'(x) + (TEX_XY_W'(y) << sh);
        return TEX_ADDR_W'(lin);
    endfunction

    always_comb begin
        level     = (mip_reg > LEVEL_W'(TEX_LOG2)) ? LEVEL_W'(TEX_LOG2) : mip_reg;
        side_log2 = LEVEL_W'(TEX_LOG2) - level;
        int_shift = 5'd16 + 5'(level);
        u_int     = COORD_W'($signed(u_reg) >>> int_shift);
        v_int     = COORD_W'($signed(v_reg) >>> int_shift);
        mask      = ~(ALL_ONES << side_log2);
        x0        = u_int[TEX_LOG2-1:0] & mask;
        y0        = v_int[TEX_LOG2-1:0] & mask;
        x1        = (x0 + 1'b1) & mask;
        y1        = (y0 + 1'b1) & mask;
        span_len  = (span_reg == '0) ? SPAN_W'(1) : span_reg;
        last      = ({1'b0, idx_reg} + 17'd1) >= {1'b0, span_len};
    end

    always_comb begin
        push_job = '0;
        if (s_item.cmd == CMD_WRITE) begin
            push_job.is_write = 1'b1;
            push_job.addr[0]  = s_item.texel_addr;
            push_job.color    = s_item.texel_color;
        end else begin
            push_job.addr[0]  = tex_addr(x0, y0, side_log2);
            push_job.addr[1]  = tex_addr(x1, y0, side_log2);
            push_job.addr[2]  = tex_addr(x0, y1, side_log2);
            push_job.addr[3]  = tex_addr(x1, y1, side_log2);
            push_job.bilinear = bilinear_reg;
            push_job.last     = last;
            if (bilinear_reg) begin
                push_job.fu = FRAC_W'($signed(u_reg) >>> level);
                push_job.fv = FRAC_W'($signed(v_reg) >>> level);
            end
        end
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;
    assign cfg_ready  = 1'b1;
    assign take       = s_valid && push_ready && (s_item.cmd == CMD_PRODUCE);

    always_comb begin
        u_next   = u_reg;
        v_next   = v_reg;
        idx_next = idx_reg;
        if (cfg_valid && (cfg_index == CFG_START_U)) begin
            u_next   = cfg_data;
            v_next   = start_v_reg;
            idx_next = '0;
        end else if (cfg_valid && (cfg_index == CFG_START_V)) begin
            u_next   = start_u_reg;
            v_next   = cfg_data;
            idx_next = '0;
        end else if (take) begin
            if (last) begin
                u_next   = start_u_reg;
                v_next   = start_v_reg;
                idx_next = '0;
            end else begin
                u_next   = u_reg + step_u_reg;
                v_next   = v_reg + step_v_reg;
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mip_reg      <= '0;
            start_u_reg  <= '0;
            start_v_reg  <= '0;
            step_u_reg   <= RST_STEP_U;
            step_v_reg   <= '0;
            bilinear_reg <= 1'b1;
            span_reg     <= RST_SPAN_LENGTH;
            u_reg        <= '0;
            v_reg        <= '0;
            idx_reg      <= '0;
        end else begin
            u_reg   <= u_next;
            v_reg   <= v_next;
            idx_reg <= idx_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MIP_LEVEL:       mip_reg      <= cfg_data[LEVEL_W-1:0];
                    CFG_START_U:         start_u_reg  <= cfg_data;
                    CFG_START_V:         start_v_reg  <= cfg_data;
                    CFG_STEP_U:          step_u_reg   <= cfg_data;
                    CFG_STEP_V:          step_v_reg   <= cfg_data;
                    CFG_FILTER_BILINEAR: bilinear_reg <= cfg_data[0];
                    CFG_SPAN_LENGTH:     span_reg     <= cfg_data[SPAN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/core/tts_queue.sv */
// ----------------------------------------------------------------------------
// tts_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module tts_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  tts_pkg::tts_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output tts_pkg::tts_job_t pop_job
);
    import tts_pkg::*;

    tts_job_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

/* rtl/core/tts_back.sv */
// ----------------------------------------------------------------------------
// tts_back
// Texel memory, tap sequencer, weighted blend and result register.
// ----------------------------------------------------------------------------
module tts_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  tts_pkg::tts_job_t pop_job,
    output logic              m_valid,
    input  logic              m_ready,
    output tts_pkg::tts_out_t m_item
);
    import tts_pkg::*;

    tts_back_state_t     state_reg, state_next;
    logic [TAP_W-1:0]    tap_reg, tap_next;
    logic [TAP_W-1:0]    tap_final;
    logic [WEIGHT_W-1:0] w_reg;
    logic                tex_vld_reg;
    logic                span_end_reg;
    logic [ACC_W-1:0]    acc_reg [NUM_CHAN];
    logic [ACC_W-1:0]    acc_next [NUM_CHAN];
    logic                out_valid_reg;
    tts_out_t            out_item_reg;

    logic                ram_we, ram_re;
    logic [COLOR_W-1:0]  ram_rdata;
    logic                load_out;
    logic [WEIGHT_W-1:0] wu, wv;
    logic [2*WEIGHT_W-1:0] w_prod;
    logic [COLOR_W-1:0]  blended;

    tts_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (TEX_DEPTH)
    ) u_tex_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (pop_job.addr[0]),
        .wr_data (pop_job.color),
        .rd_en   (ram_re),
        .rd_addr (pop_job.addr[tap_reg]),
        .rd_data (ram_rdata)
    );

    assign tap_final = pop_job.bilinear ? TAP_W'(NUM_TAPS - 1) : '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop_valid && !pop_job.is_write) begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH: begin
                if (tap_reg == tap_final) begin
                    state_next = BK_LAST;
                end
            end
            BK_LAST: state_next = BK_EMIT;
            BK_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        pop_ready = 1'b0;
        load_out  = 1'b0;
        tap_next  = tap_reg;
        case (state_reg)
            BK_IDLE: begin
                ram_we    = pop_valid && pop_job.is_write;
                pop_ready = pop_job.is_write;
                tap_next  = '0;
            end
            BK_FETCH: begin
                ram_re    = 1'b1;
                pop_ready = (tap_reg == tap_final);
                tap_next  = tap_reg + 1'b1;
            end
            BK_LAST: begin
            end
            BK_EMIT: load_out = !out_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    // tap order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
    always_comb begin
        wu     = tap_reg[0] ? WEIGHT_W'(pop_job.fu) : WEIGHT_ONE - WEIGHT_W'(pop_job.fu);
        wv     = tap_reg[1] ? WEIGHT_W'(pop_job.fv) : WEIGHT_ONE - WEIGHT_W'(pop_job.fv);
        w_prod = wu * wv;
    end

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            if (state_reg == BK_IDLE) begin
                acc_next[c] = '0;
            end else if (tex_vld_reg) begin
                acc_next[c] = acc_reg[c]
                            + ACC_W'(w_reg) * ACC_W'(ram_rdata[c*CHAN_W +: CHAN_W]);
            end else begin
                acc_next[c] = acc_reg[c];
            end
            blended[c*CHAN_W +: CHAN_W] = acc_reg[c][FRAC_W +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_prod[FRAC_W +: WEIGHT_W];
        for (int c = 0; c < NUM_CHAN; c++) begin
            acc_reg[c] <= acc_next[c];
        end
        if (state_reg == BK_FETCH) begin
            span_end_reg <= pop_job.last;
        end
        if (load_out) begin
            out_item_reg.pixel_color <= blended;
            out_item_reg.span_end    <= span_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            tap_reg       <= '0;
            tex_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            tex_vld_reg <= ram_re;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

/* rtl/core/tiled_texture_span_sampler.sv */
// ----------------------------------------------------------------------------
// tiled_texture_span_sampler
// Walks a span across a wrapping tiled texture and returns filtered pixels.
// ----------------------------------------------------------------------------
// Input channel s_*: a write item stores texel_color at texel_addr; a produce
// item samples at the current coordinates and steps them on. Each produce
// item gives one result on m_*, a write item gives none. Registers are to be
// written on cfg_* (always ready) only while no item is in flight; the block
// does not enforce this. Writes are taken one per cycle while the back end is
// idle. A bilinear pixel occupies the back end for a dispatch step, four texel
// reads through the single texture memory read port, a drain step and a load
// into the result register; a nearest pixel makes one texel read.
// A two-entry job queue separates acceptance from the back end, so items are
// still taken while a result waits. When the receiver stalls, the result
// register holds and the back end waits at its final step.
// Reset restores the register defaults and restarts the span; the texture
// memory is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module tiled_texture_span_sampler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tts_pkg::tts_in_t               s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tts_pkg::tts_out_t              m_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tts_pkg::*;

    logic     push_valid, push_ready;
    logic     pop_valid, pop_ready;
    tts_job_t push_job, pop_job;

    tts_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    tts_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    tts_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

/* rtl/core/tts_checker.sv */
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks on the span sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "tiled_texture_span_sampler_assert.svh"

module tts_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input tts_pkg::tts_out_t m_item,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    `TTS_ASSERT_RUN(a_out_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `TTS_ASSERT_RUN(a_out_stable, m_valid && !m_ready |=> $stable(m_item), "stalled result changed")
    `TTS_ASSERT_ALL(a_reset_clear, !aresetn |=> !m_valid, "result valid after reset")
    `TTS_ASSERT_RUN(a_cfg_ready, cfg_valid |-> cfg_ready, "register write refused")

endmodule

bind tiled_texture_span_sampler tts_checker u_tts_checker (.*);

/* tb/tiled_texture_span_sampler_test.sv */
// ----------------------------------------------------------------------------
// tiled_texture_span_sampler_test
// Fills the texel block that the coarser levels use, then runs directed and
// random spans over many register settings. Each pixel is predicted from a
// private copy of the texture, registers and span walk, and checked in order
// as it arrives.
// ----------------------------------------------------------------------------
module tiled_texture_span_sampler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 20;
    localparam int PHASE_ITEMS  = 60;
    localparam int MIN_LEVEL    = 4;
    localparam int FILL_TEXELS  = 1 << (2 * (TEX_LOG2 - MIN_LEVEL));

    class span_pixel_scoreboard;
        logic [LEVEL_W-1:0] mip;
        logic [31:0]        start_u, start_v, step_u, step_v;
        logic               bilinear;
        logic [SPAN_W-1:0]  span_len;
        logic [31:0]        u, v;
        logic [SPAN_W-1:0]  pix_idx;
        logic [COLOR_W-1:0] texels [TEX_DEPTH];
        tts_out_t           expected_pixels [$];
        int                 mismatches;

        function new();
            mip        = '0;
            start_u    = '0;
            start_v    = '0;
            step_u     = RST_STEP_U;
            step_v     = '0;
            bilinear   = 1'b1;
            span_len   = RST_SPAN_LENGTH;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            u       = start_u;
            v       = start_v;
            pix_idx = '0;
        endfunction

        function void write_config(tts_cfg_idx_t idx, logic [31:0] d);
            case (idx)
                CFG_MIP_LEVEL:       mip = d[LEVEL_W-1:0];
                CFG_START_U: begin
                    start_u = d;
                    restart();
                end
                CFG_START_V: begin
                    start_v = d;
                    restart();
                end
                CFG_STEP_U:          step_u = d;
                CFG_STEP_V:          step_v = d;
                CFG_FILTER_BILINEAR: bilinear = d[0];
                CFG_SPAN_LENGTH:     span_len = d[SPAN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [COLOR_W-1:0] fetch(int unsigned x, int unsigned y, int unsigned s);
            return texels[TEX_ADDR_W'(x + (y << s))];
        endfunction

        function tts_out_t sample_pixel();
            int unsigned       lvl, s, mask, x0, y0, x1, y1, len;
            int                su, sv, t;
            longint unsigned   fu, fv, iu, iv, w00, w10, w01, w11, acc;
            logic [COLOR_W-1:0] c00, c10, c01, c11, color;
            tts_out_t          px;
            lvl  = (mip > TEX_LOG2) ? TEX_LOG2 : mip;
            s    = TEX_LOG2 - lvl;
            mask = (1 << s) - 1;
            su   = u;
            sv   = v;
            t    = su >>> (16 + lvl);
            x0   = t & mask;
            t    = sv >>> (16 + lvl);
            y0   = t & mask;
            if (bilinear) begin
                x1  = (x0 + 1) & mask;
                y1  = (y0 + 1) & mask;
                t   = su >>> lvl;
                fu  = t & 32'hffff;
                t   = sv >>> lvl;
                fv  = t & 32'hffff;
                c00 = fetch(x0, y0, s);
                c10 = fetch(x1, y0, s);
                c01 = fetch(x0, y1, s);
                c11 = fetch(x1, y1, s);
                iu  = 65536 - fu;
                iv  = 65536 - fv;
                w00 = (iu * iv) >> 16;
                w10 = (fu * iv) >> 16;
                w01 = (iu * fv) >> 16;
                w11 = (fu * fv) >> 16;
                for (int sh = 0; sh < COLOR_W; sh += CHAN_W) begin
                    acc = w00 * c00[sh +: CHAN_W] + w10 * c10[sh +: CHAN_W]
                        + w01 * c01[sh +: CHAN_W] + w11 * c11[sh +: CHAN_W];
                    color[sh +: CHAN_W] = CHAN_W'(acc >> 16);
                end
            end else begin
                color = fetch(x0, y0, s);
            end
            len            = (span_len == 0) ? 1 : span_len;
            px.pixel_color = color;
            px.span_end    = (int'(pix_idx) + 1 >= len);
            if (px.span_end) begin
                restart();
            end else begin
                u       = u + step_u;
                v       = v + step_v;
                pix_idx = pix_idx + 1'b1;
            end
            return px;
        endfunction

        function void note_item(tts_in_t it);
            if (it.cmd == CMD_WRITE) begin
                texels[it.texel_addr] = it.texel_color;
            end else begin
                expected_pixels.push_back(sample_pixel());
            end
        endfunction

        function void check_pixel(tts_out_t got);
            tts_out_t exp;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected pixel: color %h end %b", got.pixel_color, got.span_end);
                end
                return;
            end
            exp = expected_pixels.pop_front();
            if (got.pixel_color !== exp.pixel_color || got.span_end !== exp.span_end) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("pixel differs: expected color %h end %b, got color %h end %b",
                             exp.pixel_color, exp.span_end, got.pixel_color, got.span_end);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    tts_in_t               s_item;
    logic                  m_valid;
    logic                  m_ready;
    tts_out_t              m_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int  idle_pct;
    bit  hold_req;
    span_pixel_scoreboard sb = new();

    tiled_texture_span_sampler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("tiled_texture_span_sampler: mismatch");
        $finish;
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic tts_in_t write_item(logic [TEX_ADDR_W-1:0] a, logic [COLOR_W-1:0] c);
        tts_in_t it;
        it.cmd         = CMD_WRITE;
        it.texel_addr  = a;
        it.texel_color = c;
        return it;
    endfunction

    function automatic tts_in_t produce_item();
        tts_in_t it;
        it.cmd         = CMD_PRODUCE;
        it.texel_addr  = TEX_ADDR_W'($urandom);
        it.texel_color = COLOR_W'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3, 4:    return $urandom;
            default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
        endcase
    endfunction

    function automatic logic [31:0] pick_span();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd65535;
            3:       return $urandom_range(0, 65535);
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    function automatic logic [31:0] pick_mip();
        case ($urandom_range(0, 7))
            0:       return 32'd15;
            1:       return $urandom_range(9, 15);
            default: return $urandom_range(MIN_LEVEL, TEX_LOG2);
        endcase
    endfunction

    // receiver: random stalls, plus one long hold on request
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                n = pick_gap();
                repeat (n) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_pixel(m_item);
        end
    end

    task automatic send_item(tts_in_t it);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
    endtask

    task automatic write_reg(tts_cfg_idx_t idx, logic [31:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_config(idx, d);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, then wait out every pixel and any trailing writes
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_pct  = 0;
        hold_req  = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill every texel that the coarser levels can reach
        for (int a = 0; a < FILL_TEXELS; a++) begin
            send_item(write_item(TEX_ADDR_W'(a), COLOR_W'($urandom)));
        end
        drain();
        write_reg(CFG_MIP_LEVEL, MIN_LEVEL);

        // directed spans
        send_item(write_item(16'h0000, 24'h000000));
        send_item(write_item(16'hffff, 24'hffffff));
        send_item(write_item(16'h0001, 24'hffffff));
        repeat (4) send_item(produce_item());
        drain();

        write_reg(CFG_START_U, 32'h0000_8000);
        write_reg(CFG_START_V, 32'hffff_8000);
        write_reg(CFG_STEP_U, 32'h7fff_ffff);
        write_reg(CFG_STEP_V, 32'h8000_0000);
        write_reg(CFG_SPAN_LENGTH, 32'd3);
        repeat (4) send_item(produce_item());
        drain();

        write_reg(CFG_MIP_LEVEL, 32'd15);
        write_reg(CFG_FILTER_BILINEAR, 32'd0);
        write_reg(CFG_SPAN_LENGTH, 32'd0);
        repeat (3) send_item(produce_item());
        drain();

        write_reg(CFG_MIP_LEVEL, TEX_LOG2);
        write_reg(CFG_FILTER_BILINEAR, 32'd1);
        send_item(write_item(16'h0000, 24'h80ff01));
        repeat (2) send_item(produce_item());
        drain();

        // random spans over changing settings
        for (int p = 0; p < PHASES; p++) begin
            if ($urandom_range(0, 1)) write_reg(CFG_MIP_LEVEL, pick_mip());
            if ($urandom_range(0, 2) == 0) write_reg(CFG_START_U, pick_coord());
            if ($urandom_range(0, 2) == 0) write_reg(CFG_START_V, pick_coord());
            if ($urandom_range(0, 1)) write_reg(CFG_STEP_U, pick_step());
            if ($urandom_range(0, 1)) write_reg(CFG_STEP_V, pick_step());
            if ($urandom_range(0, 1)) write_reg(CFG_FILTER_BILINEAR, $urandom_range(0, 1));
            if ($urandom_range(0, 1)) write_reg(CFG_SPAN_LENGTH, pick_span());
            idle_pct = (p % 5 == 0) ? 0 : 30;
            if (p == 3) begin
                idle_pct = 0;
                hold_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_item(write_item(TEX_ADDR_W'($urandom_range(0, FILL_TEXELS - 1)),
                                         COLOR_W'($urandom)));
                end else begin
                    send_item(produce_item());
                end
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
            $display("tiled_texture_span_sampler: match");
        end else begin
            $display("tiled_texture_span_sampler: mismatch");
        end
        $finish;
    end

endmodule
